FILE: src/tprl_pkg.sv
// tprl_pkg: shared types and constants for the transmit pacing limiter
// operation codes, register map and reset values; no dependencies
package tprl_pkg;

    localparam int unsigned TIME_W   = 32;
    localparam int unsigned COUNT_W  = 8;
    localparam int unsigned MODE_W   = 3;
    localparam int unsigned DATA_W   = 32;
    localparam int unsigned ADDR_W   = 4;
    localparam int unsigned REG_IDX_W = 2;

    typedef enum logic [MODE_W-1:0] {
        MODE_TX_REQ     = 3'd0,
        MODE_RETRY_QRY  = 3'd1,
        MODE_MARK_RETRY = 3'd2,
        MODE_ADD_DELAY  = 3'd3,
        MODE_START_SLOW = 3'd4
    } mode_t;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_NORMAL_DELAY = 2'd0,
        REG_SLOW_DELAY   = 2'd1,
        REG_SLOW_PERIOD  = 2'd2,
        REG_RETRY_LIMIT  = 2'd3
    } reg_idx_t;

    localparam logic [TIME_W-1:0]  NORMAL_DELAY_RST = 32'd20;
    localparam logic [TIME_W-1:0]  SLOW_DELAY_RST   = 32'd200;
    localparam logic [TIME_W-1:0]  SLOW_PERIOD_RST  = 32'd20000;
    localparam logic [COUNT_W-1:0] RETRY_LIMIT_RST  = 8'd3;
    localparam logic [TIME_W-1:0]  NEXT_ALLOWED_RST = 32'd199;

endpackage

FILE: src/tx_pacing_retransmit_limiter.sv
// tx_pacing_retransmit_limiter: transmit pacing and retransmission limiter
// path: a beat is held in the input register, then its answer in the result register
// throughput: one beat per cycle unless out_stall holds; the single state update pass sets this
// reset: rst_n clears the registers to 20/200/20000/3, next allowed time to 199,
//        the retry flag, retry count and slow period end to zero, and both pipeline stages
// depends on tprl_pkg
module tx_pacing_retransmit_limiter (
    input  logic                          clk,
    input  logic                          rst_n,
    // configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [tprl_pkg::ADDR_W-1:0]   paddr,
    input  logic [tprl_pkg::DATA_W-1:0]   pwdata,
    output logic [tprl_pkg::DATA_W-1:0]   prdata,
    output logic                          pready,
    // input beats
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [tprl_pkg::MODE_W-1:0]   mode,
    input  logic [tprl_pkg::TIME_W-1:0]   now_ms,
    input  logic [tprl_pkg::TIME_W-1:0]   extra_delay_ms,
    // result beats
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          answer
);
    import tprl_pkg::*;

    // configuration registers
    logic [TIME_W-1:0]  normal_delay_reg;
    logic [TIME_W-1:0]  slow_delay_reg;
    logic [TIME_W-1:0]  slow_period_reg;
    logic [COUNT_W-1:0] retry_limit_reg;

    // operating state
    logic [TIME_W-1:0]  next_allowed_reg, next_allowed_next;
    logic               retry_pending_reg, retry_pending_next;
    logic [COUNT_W-1:0] retry_count_reg, retry_count_next;
    logic [TIME_W-1:0]  slow_end_reg, slow_end_next;

    // input stage
    logic               s1_valid_reg;
    logic [MODE_W-1:0]  s1_mode_reg;
    logic [TIME_W-1:0]  s1_now_reg;
    logic [TIME_W-1:0]  s1_extra_reg;

    // result stage
    logic               out_valid_reg;
    logic               answer_reg, answer_next;

    logic               cfg_write;
    reg_idx_t           cfg_idx;
    logic               out_adv;   // result register can take a new beat
    logic               s1_fire;   // input stage beat is processed this cycle
    logic               in_fire;

    // ---------------------------------------------------------------
    // configuration port: always ready, register index from word address
    // ---------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_idx   = reg_idx_t'(paddr[REG_IDX_W+1:2]);
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        case (cfg_idx)
            REG_NORMAL_DELAY: prdata = normal_delay_reg;
            REG_SLOW_DELAY:   prdata = slow_delay_reg;
            REG_SLOW_PERIOD:  prdata = slow_period_reg;
            REG_RETRY_LIMIT:  prdata = {{(DATA_W-COUNT_W){1'b0}}, retry_limit_reg};
            default:          prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            normal_delay_reg <= NORMAL_DELAY_RST;
            slow_delay_reg   <= SLOW_DELAY_RST;
            slow_period_reg  <= SLOW_PERIOD_RST;
            retry_limit_reg  <= RETRY_LIMIT_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_idx)
                REG_NORMAL_DELAY: normal_delay_reg <= pwdata;
                REG_SLOW_DELAY:   slow_delay_reg   <= pwdata;
                REG_SLOW_PERIOD:  slow_period_reg  <= pwdata;
                REG_RETRY_LIMIT:  retry_limit_reg  <= pwdata[COUNT_W-1:0];
                default:          ;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // handshake: the result register parts the two sides, so a new
    // beat enters while the previous answer still waits
    // ---------------------------------------------------------------
    assign out_adv  = !out_valid_reg || !out_stall;
    assign s1_fire  = s1_valid_reg && out_adv;
    assign in_stall = s1_valid_reg && !out_adv;
    assign in_fire  = in_valid && !in_stall;

    // input stage loads whenever it is empty or its beat moves on
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    // input payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_mode_reg  <= mode;
            s1_now_reg   <= now_ms;
            s1_extra_reg <= extra_delay_ms;
        end
    end

    // ---------------------------------------------------------------
    // single pass: at most two compares and one add per operation
    // ---------------------------------------------------------------
    always_comb
    begin
        next_allowed_next  = next_allowed_reg;
        retry_pending_next = retry_pending_reg;
        retry_count_next   = retry_count_reg;
        slow_end_next      = slow_end_reg;
        answer_next        = 1'b0;
        case (mode_t'(s1_mode_reg))
            MODE_TX_REQ:
            begin
                // grant only strictly after the next allowed time; spacing
                // accumulates on the allowed time, not on now
                if (s1_now_reg > next_allowed_reg)
                begin
                    if (s1_now_reg < slow_end_reg)
                        next_allowed_next = next_allowed_reg + slow_delay_reg;
                    else
                        next_allowed_next = next_allowed_reg + normal_delay_reg;
                    answer_next = 1'b1;
                end
            end
            MODE_RETRY_QRY:
            begin
                // flag is consumed; count runs up to the limit, else clears
                retry_pending_next = 1'b0;
                if (retry_pending_reg && (retry_count_reg < retry_limit_reg))
                begin
                    retry_count_next = retry_count_reg + 1'b1;
                    answer_next      = 1'b1;
                end
                else
                begin
                    retry_count_next = '0;
                end
            end
            MODE_MARK_RETRY:
            begin
                retry_pending_next = 1'b1;
                next_allowed_next  = next_allowed_reg + slow_delay_reg;
            end
            MODE_ADD_DELAY:
            begin
                next_allowed_next = next_allowed_reg + s1_extra_reg;
            end
            MODE_START_SLOW:
            begin
                slow_end_next = s1_now_reg + slow_period_reg;
            end
            default:
            begin
                // unused codes leave the state alone and answer zero
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            next_allowed_reg  <= NEXT_ALLOWED_RST;
            retry_pending_reg <= 1'b0;
            retry_count_reg   <= '0;
            slow_end_reg      <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            if (s1_fire)
            begin
                next_allowed_reg  <= next_allowed_next;
                retry_pending_reg <= retry_pending_next;
                retry_count_reg   <= retry_count_next;
                slow_end_reg      <= slow_end_next;
            end
            if (out_adv)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    // result payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (s1_fire)
        begin
            answer_reg <= answer_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign answer    = answer_reg;

    // ---------------------------------------------------------------
    // assertions
    // ---------------------------------------------------------------
    a_stage_to_result: assert property (@(posedge clk) disable iff (!rst_n)
        s1_fire |=> out_valid_reg)
        else $error("processed beat did not reach the result register");

    a_answer_modes: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_fire && (s1_mode_reg != MODE_TX_REQ) && (s1_mode_reg != MODE_RETRY_QRY))
        |=> !answer_reg)
        else $error("answer set for an operation that gives no verdict");

    a_mark_sets_flag: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_fire && (s1_mode_reg == MODE_MARK_RETRY)) |=> retry_pending_reg)
        else $error("retransmit mark did not set the pending flag");

    a_state_holds_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !s1_fire |=> ($stable(next_allowed_reg) && $stable(retry_count_reg)
                      && $stable(slow_end_reg)))
        else $error("state changed without a processed beat");

endmodule

FILE: test/tprl_checker.sv
// tprl_checker: watches the config port and both beat channels of the pacing limiter,
// predicts every answer from its own copy of registers and state and compares in order
// depends on tprl_pkg
module tprl_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [tprl_pkg::ADDR_W-1:0]   paddr,
    input  logic [tprl_pkg::DATA_W-1:0]   pwdata,
    input  logic                          pready,
    input  logic                          in_valid,
    input  logic                          in_stall,
    input  logic [tprl_pkg::MODE_W-1:0]   mode,
    input  logic [tprl_pkg::TIME_W-1:0]   now_ms,
    input  logic [tprl_pkg::TIME_W-1:0]   extra_delay_ms,
    input  logic                          out_valid,
    input  logic                          out_stall,
    input  logic                          answer,
    output int                            mismatches,
    output int                            pending
);
    import tprl_pkg::*;

    typedef struct {
        logic [MODE_W-1:0] op;
        logic              verdict;
        int                beat_no;
    } answer_exp_t;

    answer_exp_t answer_q[$];

    logic [TIME_W-1:0]  normal_delay;
    logic [TIME_W-1:0]  slow_delay;
    logic [TIME_W-1:0]  slow_period;
    logic [COUNT_W-1:0] retry_limit;
    logic [TIME_W-1:0]  next_allowed;
    logic [TIME_W-1:0]  slow_end;
    logic               retry_pending;
    logic [COUNT_W-1:0] retry_count;
    int                 beats_in;

    // apply one operation to the shadow state, return the expected answer
    function automatic logic limiter_answer(input logic [MODE_W-1:0] op,
                                            input logic [TIME_W-1:0] now,
                                            input logic [TIME_W-1:0] extra);
        logic verdict;
        verdict = 1'b0;
        case (op)
            MODE_TX_REQ:
                if (now > next_allowed)
                begin
                    next_allowed = next_allowed + ((now < slow_end) ? slow_delay : normal_delay);
                    verdict = 1'b1;
                end
            MODE_RETRY_QRY:
            begin
                if (retry_pending && (retry_count < retry_limit))
                begin
                    retry_count = retry_count + 1'b1;
                    verdict = 1'b1;
                end
                else
                begin
                    retry_count = '0;
                end
                retry_pending = 1'b0;
            end
            MODE_MARK_RETRY:
            begin
                retry_pending = 1'b1;
                next_allowed = next_allowed + slow_delay;
            end
            MODE_ADD_DELAY:
                next_allowed = next_allowed + extra;
            MODE_START_SLOW:
                slow_end = now + slow_period;
            default:
                verdict = 1'b0;
        endcase
        return verdict;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        answer_exp_t exp_beat;
        if (!rst_n)
        begin
            normal_delay  = NORMAL_DELAY_RST;
            slow_delay    = SLOW_DELAY_RST;
            slow_period   = SLOW_PERIOD_RST;
            retry_limit   = RETRY_LIMIT_RST;
            next_allowed  = NEXT_ALLOWED_RST;
            slow_end      = '0;
            retry_pending = 1'b0;
            retry_count   = '0;
            beats_in      = 0;
            mismatches    = 0;
            answer_q.delete();
            pending <= 0;
        end
        else
        begin
            // register index comes from the word address only
            if (psel && penable && pwrite && pready)
            begin
                case (reg_idx_t'(paddr[REG_IDX_W+1:2]))
                    REG_NORMAL_DELAY: normal_delay = pwdata;
                    REG_SLOW_DELAY:   slow_delay   = pwdata;
                    REG_SLOW_PERIOD:  slow_period  = pwdata;
                    REG_RETRY_LIMIT:  retry_limit  = pwdata[COUNT_W-1:0];
                    default:          ;
                endcase
            end

            if (in_valid && !in_stall)
            begin
                exp_beat.op      = mode;
                exp_beat.verdict = limiter_answer(mode, now_ms, extra_delay_ms);
                exp_beat.beat_no = beats_in;
                answer_q.push_back(exp_beat);
                beats_in++;
            end

            if (out_valid && !out_stall)
            begin
                if (answer_q.size() == 0)
                begin
                    if (mismatches < 10)
                        $display("answer beat %0b arrived with nothing pending", answer);
                    mismatches++;
                end
                else
                begin
                    exp_beat = answer_q.pop_front();
                    if (answer !== exp_beat.verdict)
                    begin
                        if (mismatches < 10)
                            $display("answer mismatch on beat %0d (mode %0d): expected %0b got %0b",
                                     exp_beat.beat_no, exp_beat.op, exp_beat.verdict, answer);
                        mismatches++;
                    end
                end
            end

            pending <= answer_q.size();
        end
    end

endmodule

FILE: test/testbench.sv
// testbench: top of the pacing limiter bench; drives reset, config writes and op beats
// with random idling on both channels, and reports the verdict from tprl_checker
// depends on tprl_pkg, tx_pacing_retransmit_limiter and tprl_checker
module testbench;
    import tprl_pkg::*;

    // watchdog limit, set with a wide margin over the slowest run
    localparam int LIMIT_CYCLES = 200000;
    localparam int PHASE_BEATS  = 142;

    logic                clk;
    logic                rst_n          = 1'b0;
    logic                psel           = 1'b0;
    logic                penable        = 1'b0;
    logic                pwrite         = 1'b0;
    logic [ADDR_W-1:0]   paddr          = '0;
    logic [DATA_W-1:0]   pwdata         = '0;
    logic [DATA_W-1:0]   prdata;
    logic                pready;
    logic                in_valid       = 1'b0;
    logic                in_stall;
    logic [MODE_W-1:0]   mode           = '0;
    logic [TIME_W-1:0]   now_ms         = '0;
    logic [TIME_W-1:0]   extra_delay_ms = '0;
    logic                out_valid;
    logic                out_stall      = 1'b0;
    logic                answer;

    int                  mismatches;
    int                  pending;
    int                  cycle_cnt      = 0;

    // idle percentages of the sender and the receiver, switched between phases
    int                  send_idle_pct  = 18;
    int                  stall_pct      = 64;

    // stimulus-side notion of time; kept near the block's next allowed time so
    // that transmit requests land on both sides of the pacing threshold
    logic [TIME_W-1:0]   clock_ms       = NEXT_ALLOWED_RST;
    logic [TIME_W-1:0]   cur_slow       = SLOW_DELAY_RST;

    tx_pacing_retransmit_limiter DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .mode           (mode),
        .now_ms         (now_ms),
        .extra_delay_ms (extra_delay_ms),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .answer         (answer)
    );

    tprl_checker answer_chk (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .pready         (pready),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .mode           (mode),
        .now_ms         (now_ms),
        .extra_delay_ms (extra_delay_ms),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .answer         (answer),
        .mismatches     (mismatches),
        .pending        (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // receiver backpressure, redrawn every cycle
    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == LIMIT_CYCLES)
        begin
            $display("tx_pacing_retransmit_limiter verification failed");
            $finish;
        end
    end

    // one apb write: setup then access; psel is left high so writes can run back to back
    task automatic reg_write(input reg_idx_t idx, input logic [DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
    endtask

    // full register set, only while nothing is in flight
    task automatic load_timing(input logic [DATA_W-1:0] normal, input logic [DATA_W-1:0] slow,
                               input logic [DATA_W-1:0] period, input logic [DATA_W-1:0] limit);
        reg_write(REG_NORMAL_DELAY, normal);
        reg_write(REG_SLOW_DELAY, slow);
        reg_write(REG_SLOW_PERIOD, period);
        reg_write(REG_RETRY_LIMIT, limit);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        cur_slow = slow;
    endtask

    // present one op beat and hold it until accepted; valid stays high afterwards
    // so the next beat can follow without a bubble
    task automatic send_op(input logic [MODE_W-1:0] op, input logic [TIME_W-1:0] now,
                           input logic [TIME_W-1:0] extra);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid       <= 1'b1;
        mode           <= op;
        now_ms         <= now;
        extra_delay_ms <= extra;
        do @(posedge clk); while (in_stall);
    endtask

    // stop sending and wait until every answer is back, then let the pipeline settle
    task automatic drain_answers();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic run_ops(input int beats);
        int               done;
        int               roll;
        logic [TIME_W-1:0] t;
        logic [TIME_W-1:0] x;
        done = 0;
        while (done < beats)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 45)
            begin
                // transmit request around the current time, sometimes anywhere
                if ($urandom_range(0, 29) == 0)
                    t = $urandom;
                else
                    t = clock_ms - 2 + $urandom_range(0, 4);
                send_op(MODE_TX_REQ, t, $urandom);
                clock_ms += $urandom_range(0, 40);
                done++;
            end
            else if (roll < 68)
            begin
                // well-formed retransmit: mark then query
                send_op(MODE_MARK_RETRY, $urandom, $urandom);
                send_op(MODE_RETRY_QRY, $urandom, $urandom);
                clock_ms += cur_slow;
                done += 2;
            end
            else if (roll < 74)
            begin
                // query with no mark in front
                send_op(MODE_RETRY_QRY, $urandom, $urandom);
                done++;
            end
            else if (roll < 78)
            begin
                // mark with no query behind
                send_op(MODE_MARK_RETRY, $urandom, $urandom);
                clock_ms += cur_slow;
                done++;
            end
            else if (roll < 87)
            begin
                if ($urandom_range(0, 3) == 0)
                    x = $urandom;
                else
                    x = $urandom_range(0, 60);
                send_op(MODE_ADD_DELAY, $urandom, x);
                clock_ms += x;
                done++;
            end
            else if (roll < 94)
            begin
                send_op(MODE_START_SLOW, clock_ms, $urandom);
                done++;
            end
            else if (roll < 97)
            begin
                // unused codes are ignored by the block, so they do not count
                send_op(3'($urandom_range(5, 7)), $urandom, $urandom);
            end
            else
            begin
                clock_ms = $urandom;
            end
        end
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset timing, threshold edges, retry limit and wraparound
        send_op(MODE_TX_REQ, 32'd0, 32'd0);                   // before next allowed
        send_op(MODE_TX_REQ, 32'd199, 32'hFFFF_FFFF);         // equal, not later
        send_op(MODE_TX_REQ, 32'd200, 32'd0);                 // first grant, normal spacing
        send_op(MODE_TX_REQ, 32'hFFFF_FFFF, 32'd0);           // latest possible time
        send_op(MODE_RETRY_QRY, 32'd0, 32'd0);                // query with no flag
        repeat (4)
        begin
            // three true verdicts, then the limit clears the count
            send_op(MODE_MARK_RETRY, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
            send_op(MODE_RETRY_QRY, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        end
        send_op(MODE_RETRY_QRY, 32'd0, 32'd0);
        send_op(MODE_START_SLOW, 32'd1000, 32'd0);            // slow period until 21000
        send_op(MODE_TX_REQ, 32'd5000, 32'd0);                // inside slow period
        send_op(MODE_TX_REQ, 32'd21000, 32'd0);               // exactly at the end
        send_op(MODE_ADD_DELAY, 32'd0, 32'hFFFF_FFFF);        // wraps to one less
        send_op(MODE_ADD_DELAY, 32'd0, 32'd0);
        send_op(MODE_START_SLOW, 32'hFFFF_FFFF, 32'd0);       // end wraps past zero
        send_op(3'd5, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_op(3'd6, 32'd0, 32'd0);
        send_op(3'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_op(MODE_TX_REQ, 32'hFFFF_FFFF, 32'd0);
        drain_answers();
        clock_ms = 32'd1000;

        // sender idles lightly, receiver stalls heavily
        load_timing(32'd0, 32'd0, 32'd0, 32'd0);
        run_ops(PHASE_BEATS);
        drain_answers();
        load_timing(32'd1, 32'd5, 32'd300, 32'd1);
        run_ops(PHASE_BEATS);
        drain_answers();

        // the other way round
        send_idle_pct = 64;
        stall_pct     = 18;
        load_timing(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd255);
        run_ops(PHASE_BEATS);
        drain_answers();
        load_timing($urandom_range(0, 50), $urandom_range(0, 500), $urandom_range(0, 50000),
                    $urandom_range(0, 6));
        run_ops(PHASE_BEATS);
        drain_answers();

        // no idling at all
        send_idle_pct = 0;
        stall_pct     = 0;
        load_timing(32'd7, 32'd60, 32'd2000, 32'd2);
        run_ops(PHASE_BEATS);
        drain_answers();
        // full-width values, upper bits of the limit write included
        load_timing($urandom, $urandom, $urandom, $urandom);
        run_ops(PHASE_BEATS);
        drain_answers();

        if (mismatches == 0 && pending == 0)
            $display("tx_pacing_retransmit_limiter verification clean");
        else
            $display("tx_pacing_retransmit_limiter verification failed");
        $finish;
    end

endmodule
